### design/omdm_pkg.sv
// Shared types, constants and lookup functions for the omni drive motor mixer.
package omdm_pkg;

  localparam int MAX_MOTORS  = 4;
  localparam int ANGLE_STEPS = 360;
  localparam int MOTOR_IDX_W = 2;

  localparam int CMDQ_DEPTH = 8;
  localparam int CMDQ_AW    = $clog2(CMDQ_DEPTH);
  localparam int OUTQ_DEPTH = 8;
  localparam int OUTQ_AW    = $clog2(OUTQ_DEPTH);

  localparam logic [2:0] REG_MAX_PWM     = 3'd0;
  localparam logic [2:0] REG_MOTOR_COUNT = 3'd1;
  localparam logic [2:0] REG_ANGLE0      = 3'd2;
  localparam logic [2:0] REG_ANGLE1      = 3'd3;
  localparam logic [2:0] REG_ANGLE2      = 3'd4;
  localparam logic [2:0] REG_ANGLE3      = 3'd5;

  // Reciprocal constants for truncating division of bounded unsigned values.
  localparam int DIV5_SHIFT    = 20;
  localparam logic [17:0] DIV5_MUL = 18'((64'd1 << DIV5_SHIFT) / 5 + 1);
  localparam int DIV100_SHIFT  = 24;
  localparam logic [17:0] DIV100_MUL = 18'((64'd1 << DIV100_SHIFT) / 100 + 1);
  localparam int DIV100K_SHIFT = 45;
  localparam logic [28:0] DIV100K_MUL = 29'((64'd1 << DIV100K_SHIFT) / 100000 + 1);
  localparam int DIV20K_SHIFT  = 41;
  localparam logic [26:0] DIV20K_MUL = 27'((64'd1 << DIV20K_SHIFT) / 20000 + 1);

  localparam logic [13:0] QSINE [0:90] = '{
    14'd0,    14'd175,  14'd349,  14'd523,  14'd698,  14'd872,  14'd1045, 14'd1219,
    14'd1392, 14'd1564, 14'd1736, 14'd1908, 14'd2079, 14'd2250, 14'd2419, 14'd2588,
    14'd2756, 14'd2924, 14'd3090, 14'd3256, 14'd3420, 14'd3584, 14'd3746, 14'd3907,
    14'd4067, 14'd4226, 14'd4384, 14'd4540, 14'd4695, 14'd4848, 14'd5000, 14'd5150,
    14'd5299, 14'd5446, 14'd5592, 14'd5736, 14'd5878, 14'd6018, 14'd6157, 14'd6293,
    14'd6428, 14'd6561, 14'd6691, 14'd6820, 14'd6947, 14'd7071, 14'd7193, 14'd7314,
    14'd7431, 14'd7547, 14'd7660, 14'd7771, 14'd7880, 14'd7986, 14'd8090, 14'd8192,
    14'd8290, 14'd8387, 14'd8480, 14'd8572, 14'd8660, 14'd8746, 14'd8829, 14'd8910,
    14'd8988, 14'd9063, 14'd9135, 14'd9205, 14'd9272, 14'd9336, 14'd9397, 14'd9455,
    14'd9511, 14'd9563, 14'd9613, 14'd9659, 14'd9703, 14'd9744, 14'd9781, 14'd9816,
    14'd9848, 14'd9877, 14'd9903, 14'd9925, 14'd9945, 14'd9962, 14'd9976, 14'd9986,
    14'd9994, 14'd9998, 14'd10000
  };

  typedef struct packed {
    logic [8:0]        heading;
    logic [6:0]        speed_percent;
    logic signed [7:0] rotation_percent;
  } in_item_t;

  typedef struct packed {
    logic [MOTOR_IDX_W-1:0] motor_index;
    logic signed [11:0]     drive_value;
    logic                   forward_pin;
    logic                   backward_pin;
    logic [10:0]            duty;
    logic                   last_motor;
  } out_item_t;

  typedef struct packed {
    logic [9:0]                  max_pwm;
    logic [2:0]                  motor_count;
    logic [MAX_MOTORS-1:0][8:0]  angle;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    max_pwm:     10'd255,
    motor_count: 3'd4,
    angle:       {9'd315, 9'd225, 9'd135, 9'd45}
  };

  typedef struct packed {
    logic signed [12:0] vx;
    logic signed [12:0] vy;
    logic signed [11:0] rot;
  } cmd_t;

  typedef struct packed {
    logic             empty;
    logic [CMDQ_AW:0] level;
  } cmdq_status_t;

  typedef struct packed {
    logic        neg;
    logic [13:0] mag;
  } sine_sm_t;

  function automatic logic [8:0] angle_wrap(input logic [10:0] x);
    logic [10:0] r;
    if (x >= 11'(2 * ANGLE_STEPS)) begin
      r = x - 11'(2 * ANGLE_STEPS);
    end else if (x >= 11'(ANGLE_STEPS)) begin
      r = x - 11'(ANGLE_STEPS);
    end else begin
      r = x;
    end
    return r[8:0];
  endfunction

  function automatic sine_sm_t sine_sm(input logic [8:0] d);
    sine_sm_t    r;
    logic [8:0]  k;
    r.neg = 1'b0;
    if (d <= 9'd90) begin
      k = d;
    end else if (d <= 9'd180) begin
      k = 9'd180 - d;
    end else if (d <= 9'd270) begin
      k = d - 9'd180;
      r.neg = 1'b1;
    end else begin
      k = 9'd360 - d;
      r.neg = 1'b1;
    end
    r.mag = QSINE[k[6:0]];
    return r;
  endfunction

  function automatic logic signed [14:0] sine_signed(input sine_sm_t s);
    logic signed [14:0] m;
    m = $signed({1'b0, s.mag});
    return s.neg ? -m : m;
  endfunction

endpackage

### design/omni_drive_motor_mixer.sv
// Top level of the omni drive motor mixer: configuration registers and front/back wiring.
// The first result of an item passes the front stages s1-s4, the command queue, the current
// command register, the back stages b1-b4 and the output queue; the results for the other
// motors follow one per cycle while the output queue has room. The single per-motor
// back-end projection pipeline sets the item rate; the input is taken while results wait.
// Reset (rst_n low at a clock edge) empties both queues and restores register defaults.
module omni_drive_motor_mixer (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  output logic                full,
  input  omdm_pkg::in_item_t  in_data,
  input  logic                pop,
  output logic                empty,
  output omdm_pkg::out_item_t out_data,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_index,
  input  logic [9:0]          cfg_wdata
);
  import omdm_pkg::*;

  cfg_t         cfg_r, cfg_nxt;
  logic         cmd_wr, cmd_rd;
  cmd_t         cmd_wdata, cmd_head;
  cmdq_status_t q_status;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        REG_MAX_PWM:     cfg_nxt.max_pwm     = cfg_wdata;
        REG_MOTOR_COUNT: cfg_nxt.motor_count = cfg_wdata[2:0];
        REG_ANGLE0:      cfg_nxt.angle[0]    = cfg_wdata[8:0];
        REG_ANGLE1:      cfg_nxt.angle[1]    = cfg_wdata[8:0];
        REG_ANGLE2:      cfg_nxt.angle[2]    = cfg_wdata[8:0];
        REG_ANGLE3:      cfg_nxt.angle[3]    = cfg_wdata[8:0];
        default:         cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  omdm_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .full      (full),
    .in_data   (in_data),
    .cfg       (cfg_r),
    .q_status  (q_status),
    .cmd_wr    (cmd_wr),
    .cmd_wdata (cmd_wdata)
  );

  omdm_cmd_queue u_cmd_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr     (cmd_wr),
    .wdata  (cmd_wdata),
    .rd     (cmd_rd),
    .head   (cmd_head),
    .status (q_status)
  );

  omdm_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .q_status (q_status),
    .cmd_head (cmd_head),
    .cmd_rd   (cmd_rd),
    .pop      (pop),
    .empty    (empty),
    .out_data (out_data)
  );

endmodule

### design/omdm_front.sv
// Front end: accepts move commands and computes the heading vector and rotation share.
module omdm_front (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   push,
  output logic                   full,
  input  omdm_pkg::in_item_t     in_data,
  input  omdm_pkg::cfg_t         cfg,
  input  omdm_pkg::cmdq_status_t q_status,
  output logic                   cmd_wr,
  output omdm_pkg::cmd_t         cmd_wdata
);
  import omdm_pkg::*;

  logic        accept;
  logic [2:0]  inflight;
  logic [7:0]  rot_abs;
  logic [17:0] rot_prod;

  logic        s1_v_r, s2_v_r, s3_v_r, s4_v_r;
  logic [16:0] s1_pmag_r, s1_prot_r;
  logic        s1_rneg_r;
  sine_sm_t    s1_sc_r, s1_ss_r;

  logic [34:0] mag_full, rot_full;
  logic [14:0] s2_mag_r;
  logic [10:0] s2_rabs_r;
  logic        s2_rneg_r;
  sine_sm_t    s2_sc_r, s2_ss_r;

  logic [28:0]        px_full, py_full;
  logic [27:0]        s3_px_r, s3_py_r;
  logic               s3_xneg_r, s3_yneg_r;
  logic signed [11:0] s3_rot_r;

  logic [56:0]        qx_full, qy_full;
  logic [11:0]        s4_qx_r, s4_qy_r;
  logic               s4_xneg_r, s4_yneg_r;
  logic signed [11:0] s4_rot_r;
  logic signed [12:0] vx_pos, vy_pos;

  assign inflight = 3'(s1_v_r) + 3'(s2_v_r) + 3'(s3_v_r) + 3'(s4_v_r);
  assign full = (5'(q_status.level) + 5'(inflight)) >= 5'(CMDQ_DEPTH);
  assign accept = push && !full;

  assign rot_abs = in_data.rotation_percent[7] ? (~in_data.rotation_percent + 8'd1)
                                               : in_data.rotation_percent;
  assign rot_prod = 18'(rot_abs) * 18'(cfg.max_pwm);

  assign mag_full = 35'(s1_pmag_r) * 35'(DIV5_MUL);
  assign rot_full = 35'(s1_prot_r) * 35'(DIV100_MUL);
  assign px_full  = 29'(s2_mag_r) * 29'(s2_sc_r.mag);
  assign py_full  = 29'(s2_mag_r) * 29'(s2_ss_r.mag);
  assign qx_full  = 57'(s3_px_r) * 57'(DIV100K_MUL);
  assign qy_full  = 57'(s3_py_r) * 57'(DIV100K_MUL);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
      s4_v_r <= 1'b0;
    end else begin
      s1_v_r <= accept;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
      s4_v_r <= s3_v_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_pmag_r <= 17'(in_data.speed_percent) * 17'(cfg.max_pwm);
    s1_prot_r <= rot_prod[16:0];
    s1_rneg_r <= in_data.rotation_percent[7];
    s1_sc_r   <= sine_sm(angle_wrap(11'(in_data.heading) + 11'd90));
    s1_ss_r   <= sine_sm(angle_wrap(11'(in_data.heading)));

    s2_mag_r  <= mag_full[34:DIV5_SHIFT];
    s2_rabs_r <= rot_full[34:DIV100_SHIFT];
    s2_rneg_r <= s1_rneg_r;
    s2_sc_r   <= s1_sc_r;
    s2_ss_r   <= s1_ss_r;

    s3_px_r   <= px_full[27:0];
    s3_py_r   <= py_full[27:0];
    s3_xneg_r <= s2_sc_r.neg;
    s3_yneg_r <= s2_ss_r.neg;
    s3_rot_r  <= s2_rneg_r ? -$signed({1'b0, s2_rabs_r}) : $signed({1'b0, s2_rabs_r});

    s4_qx_r   <= qx_full[56:DIV100K_SHIFT];
    s4_qy_r   <= qy_full[56:DIV100K_SHIFT];
    s4_xneg_r <= s3_xneg_r;
    s4_yneg_r <= s3_yneg_r;
    s4_rot_r  <= s3_rot_r;
  end

  assign vx_pos = $signed({1'b0, s4_qx_r});
  assign vy_pos = $signed({1'b0, s4_qy_r});

  assign cmd_wr        = s4_v_r;
  assign cmd_wdata.vx  = s4_xneg_r ? -vx_pos : vx_pos;
  assign cmd_wdata.vy  = s4_yneg_r ? -vy_pos : vy_pos;
  assign cmd_wdata.rot = s4_rot_r;

endmodule

### design/omdm_cmd_queue.sv
// Command queue that decouples the front end from the per-motor back end.
module omdm_cmd_queue (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   wr,
  input  omdm_pkg::cmd_t         wdata,
  input  logic                   rd,
  output omdm_pkg::cmd_t         head,
  output omdm_pkg::cmdq_status_t status
);
  import omdm_pkg::*;

  cmd_t               mem_r [CMDQ_DEPTH];
  logic [CMDQ_AW-1:0] wptr_r, rptr_r;
  logic [CMDQ_AW:0]   level_r, level_nxt;

  always_comb begin
    level_nxt = level_r;
    if (wr && !rd) begin
      level_nxt = level_r + 1'b1;
    end else if (rd && !wr) begin
      level_nxt = level_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      level_r <= '0;
    end else begin
      if (wr) begin
        wptr_r <= wptr_r + 1'b1;
      end
      if (rd) begin
        rptr_r <= rptr_r + 1'b1;
      end
      level_r <= level_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr) begin
      mem_r[wptr_r] <= wdata;
    end
  end

  assign head         = mem_r[rptr_r];
  assign status.empty = (level_r == '0);
  assign status.level = level_r;

endmodule

### design/omdm_back.sv
// Back end: projects each command onto the wheel axes and queues one result per motor.
module omdm_back (
  input  logic                   clk,
  input  logic                   rst_n,
  input  omdm_pkg::cfg_t         cfg,
  input  omdm_pkg::cmdq_status_t q_status,
  input  omdm_pkg::cmd_t         cmd_head,
  output logic                   cmd_rd,
  input  logic                   pop,
  output logic                   empty,
  output omdm_pkg::out_item_t    out_data
);
  import omdm_pkg::*;

  logic                   active_r, active_nxt;
  logic [MOTOR_IDX_W-1:0] motor_r, motor_nxt;
  logic [2:0]             count_r, count_nxt;
  cmd_t                   cur_r, cur_nxt;
  logic [2:0]             eff_count;
  logic [2:0]             inflight;
  logic                   credit_ok, issue, issue_last;
  logic [8:0]             angle;

  logic                   b1_v_r, b2_v_r, b3_v_r, b4_v_r;
  logic signed [12:0]     b1_vx_r, b1_vy_r;
  logic signed [14:0]     b1_ax_r, b1_ay_r;
  logic signed [11:0]     b1_rot_r, b2_rot_r, b3_rot_r, b4_rot_r;
  logic [MOTOR_IDX_W-1:0] b1_idx_r, b2_idx_r, b3_idx_r, b4_idx_r;
  logic                   b1_last_r, b2_last_r, b3_last_r, b4_last_r;

  logic signed [27:0] px_full, py_full;
  logic signed [25:0] b2_px_r, b2_py_r;
  logic signed [26:0] sum;
  logic [26:0]        sum_neg;
  logic [25:0]        b3_abs_r;
  logic               b3_neg_r, b4_neg_r;
  logic [52:0]        b4_prod_r;

  logic [11:0]        q;
  logic signed [12:0] vq, v, v_neg;
  out_item_t          res;

  out_item_t          omem_r [OUTQ_DEPTH];
  logic [OUTQ_AW-1:0] owptr_r, orptr_r;
  logic [OUTQ_AW:0]   olevel_r, olevel_nxt;
  logic               oread;

  assign eff_count = (cfg.motor_count > 3'(MAX_MOTORS)) ? 3'(MAX_MOTORS) : cfg.motor_count;
  assign inflight  = 3'(b1_v_r) + 3'(b2_v_r) + 3'(b3_v_r) + 3'(b4_v_r);
  assign credit_ok = (5'(olevel_r) + 5'(inflight)) < 5'(OUTQ_DEPTH);
  assign issue      = active_r && credit_ok;
  assign issue_last = issue && ((3'(motor_r) + 3'd1) == count_r);
  assign cmd_rd     = (!active_r || issue_last) && !q_status.empty;

  always_comb begin
    active_nxt = active_r;
    motor_nxt  = motor_r;
    count_nxt  = count_r;
    cur_nxt    = cur_r;
    if (cmd_rd) begin
      active_nxt = (eff_count != 3'd0);
      motor_nxt  = '0;
      count_nxt  = eff_count;
      cur_nxt    = cmd_head;
    end else if (issue_last) begin
      active_nxt = 1'b0;
    end else if (issue) begin
      motor_nxt = motor_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      motor_r  <= '0;
      count_r  <= '0;
    end else begin
      active_r <= active_nxt;
      motor_r  <= motor_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
  end

  assign angle = cfg.angle[motor_r];

  assign px_full = 28'(b1_vx_r) * 28'(b1_ax_r);
  assign py_full = 28'(b1_vy_r) * 28'(b1_ay_r);
  assign sum     = 27'(b2_px_r) + 27'(b2_py_r);
  assign sum_neg = -sum;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b1_v_r <= 1'b0;
      b2_v_r <= 1'b0;
      b3_v_r <= 1'b0;
      b4_v_r <= 1'b0;
    end else begin
      b1_v_r <= issue;
      b2_v_r <= b1_v_r;
      b3_v_r <= b2_v_r;
      b4_v_r <= b3_v_r;
    end
  end

  always_ff @(posedge clk) begin
    b1_vx_r   <= cur_r.vx;
    b1_vy_r   <= cur_r.vy;
    b1_ax_r   <= sine_signed(sine_sm(angle_wrap(11'(angle) + 11'd540)));
    b1_ay_r   <= sine_signed(sine_sm(angle_wrap(11'(angle) + 11'd450)));
    b1_rot_r  <= cur_r.rot;
    b1_idx_r  <= motor_r;
    b1_last_r <= issue_last;

    b2_px_r   <= px_full[25:0];
    b2_py_r   <= py_full[25:0];
    b2_rot_r  <= b1_rot_r;
    b2_idx_r  <= b1_idx_r;
    b2_last_r <= b1_last_r;

    b3_neg_r  <= sum[26];
    b3_abs_r  <= sum[26] ? sum_neg[25:0] : sum[25:0];
    b3_rot_r  <= b2_rot_r;
    b3_idx_r  <= b2_idx_r;
    b3_last_r <= b2_last_r;

    b4_prod_r <= 53'(b3_abs_r) * 53'(DIV20K_MUL);
    b4_neg_r  <= b3_neg_r;
    b4_rot_r  <= b3_rot_r;
    b4_idx_r  <= b3_idx_r;
    b4_last_r <= b3_last_r;
  end

  assign q     = b4_prod_r[52:DIV20K_SHIFT];
  assign vq    = b4_neg_r ? -$signed({1'b0, q}) : $signed({1'b0, q});
  assign v     = vq + 13'(b4_rot_r);
  assign v_neg = -v;

  always_comb begin
    res.motor_index  = b4_idx_r;
    res.drive_value  = v[11:0];
    res.forward_pin  = !v[12] && (v != '0);
    res.backward_pin = v[12] || (v == '0);
    res.duty         = v[12] ? v_neg[10:0] : v[10:0];
    res.last_motor   = b4_last_r;
  end

  assign oread = pop && !empty;

  always_comb begin
    olevel_nxt = olevel_r;
    if (b4_v_r && !oread) begin
      olevel_nxt = olevel_r + 1'b1;
    end else if (oread && !b4_v_r) begin
      olevel_nxt = olevel_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      owptr_r  <= '0;
      orptr_r  <= '0;
      olevel_r <= '0;
    end else begin
      if (b4_v_r) begin
        owptr_r <= owptr_r + 1'b1;
      end
      if (oread) begin
        orptr_r <= orptr_r + 1'b1;
      end
      olevel_r <= olevel_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (b4_v_r) begin
      omem_r[owptr_r] <= res;
    end
  end

  assign empty    = (olevel_r == '0);
  assign out_data = omem_r[orptr_r];

endmodule

### design/omdm_checker.sv
// Port-level checker for the omni drive motor mixer, bound to the top level.
module omdm_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                full,
  input logic                pop,
  input logic                empty,
  input omdm_pkg::out_item_t out_data
);
  import omdm_pkg::*;

  a_reset_clears: assert property (@(posedge clk) !rst_n |=> empty && !full)
    else $error("queues not empty after reset");

  a_pins_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    !empty |-> (out_data.forward_pin != out_data.backward_pin))
    else $error("direction pins not exclusive");

  a_top_motor_last: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && (out_data.motor_index == 2'(MAX_MOTORS - 1))) |-> out_data.last_motor)
    else $error("highest motor result not marked last");

  a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !pop) |=> (!empty && $stable(out_data)))
    else $error("waiting result changed");

endmodule

bind omni_drive_motor_mixer omdm_checker u_omdm_checker (.*);
